// ===== rtl/stsc_pkg.sv =====
// Shared constants and types for the sorted table search and count block.
`default_nettype none
package stsc_pkg;

   localparam int unsigned TABLE_DEPTH = 1024;
   localparam int unsigned INDEX_W     = 10;
   localparam int unsigned LEN_W       = 11;
   localparam int unsigned COUNT_W     = 11;
   localparam int unsigned DATA_W      = 32;
   // Signed position: one bit for the sign and one to hold TABLE_DEPTH itself.
   localparam int unsigned PTR_W       = INDEX_W + 2;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      op_type                    operation;
      logic [INDEX_W-1:0]        entry_index;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic                      found;
      logic [INDEX_W-1:0]        hit_index;
      logic [COUNT_W-1:0]        occurrences;
   } rsp_type;

   typedef struct packed {
      logic                      wr_en;
      logic [INDEX_W-1:0]        wr_addr;
      logic signed [DATA_W-1:0]  wr_data;
      logic                      rd_en;
      logic [INDEX_W-1:0]        rd_addr;
   } mem_req_type;

endpackage
`default_nettype wire

// ===== rtl/stsc_table_ram.sv =====
// Table memory: one write port and one read port with registered read data.
`default_nettype none
module stsc_table_ram (
   input  wire                                   clock,
   input  wire stsc_pkg::mem_req_type            mem_req,
   output logic signed [stsc_pkg::DATA_W-1:0]    rd_data
);

   logic signed [stsc_pkg::DATA_W-1:0] mem_ff [stsc_pkg::TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data <= mem_ff[mem_req.rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/stsc_search_ctrl.sv =====
// Sequencer for table writes, the binary search and the occurrence scan.
`default_nettype none
module stsc_search_ctrl (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire stsc_pkg::req_type                req_data,
   input  wire [stsc_pkg::LEN_W-1:0]             used_len,
   input  wire                                   rsp_free,
   output logic                                  result_valid,
   output stsc_pkg::rsp_type                     result,
   output stsc_pkg::mem_req_type                 mem_req,
   input  wire signed [stsc_pkg::DATA_W-1:0]     rd_data
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_B_ADDR = 8'b0000_0010,
      ST_B_CMP  = 8'b0000_0100,
      ST_L_ADDR = 8'b0000_1000,
      ST_L_CMP  = 8'b0001_0000,
      ST_R_ADDR = 8'b0010_0000,
      ST_R_CMP  = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type                               state_ff, state_in;
   logic signed [stsc_pkg::PTR_W-1:0]       low_ff, low_in;
   logic signed [stsc_pkg::PTR_W-1:0]       high_ff, high_in;
   logic signed [stsc_pkg::PTR_W-1:0]       ptr_ff, ptr_in;
   logic signed [stsc_pkg::DATA_W-1:0]      key_ff, key_in;
   logic                                    found_ff, found_in;
   logic [stsc_pkg::INDEX_W-1:0]            hit_ff, hit_in;
   logic [stsc_pkg::COUNT_W-1:0]            count_ff, count_in;
   logic signed [stsc_pkg::PTR_W-1:0]       len_s;
   logic signed [stsc_pkg::PTR_W-1:0]       hit_next_s;
   logic signed [stsc_pkg::PTR_W-1:0]       span;
   logic signed [stsc_pkg::PTR_W-1:0]       mid;

   assign len_s      = $signed({1'b0, used_len});
   assign hit_next_s = $signed({2'b00, hit_ff}) + stsc_pkg::PTR_W'(1);
   assign span       = high_ff - low_ff;
   assign mid        = low_ff + (span >>> 1);

   always_comb begin
      state_in          = state_ff;
      low_in            = low_ff;
      high_in           = high_ff;
      ptr_in            = ptr_ff;
      key_in            = key_ff;
      found_in          = found_ff;
      hit_in            = hit_ff;
      count_in          = count_ff;
      req_stall         = 1'b1;
      result_valid      = 1'b0;
      mem_req.wr_en     = 1'b0;
      mem_req.wr_addr   = req_data.entry_index;
      mem_req.wr_data   = req_data.value;
      mem_req.rd_en     = 1'b0;
      mem_req.rd_addr   = ptr_ff[stsc_pkg::INDEX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_data.operation == stsc_pkg::OP_WRITE) begin
                  mem_req.wr_en = (32'(req_data.entry_index) < stsc_pkg::TABLE_DEPTH);
               end else begin
                  key_in   = req_data.value;
                  low_in   = '0;
                  high_in  = len_s - stsc_pkg::PTR_W'(1);
                  found_in = 1'b0;
                  hit_in   = '0;
                  count_in = '0;
                  state_in = ST_B_ADDR;
               end
            end
         end
         ST_B_ADDR: begin
            if (low_ff <= high_ff) begin
               ptr_in          = mid;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = mid[stsc_pkg::INDEX_W-1:0];
               state_in        = ST_B_CMP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_B_CMP: begin
            if (rd_data == key_ff) begin
               found_in = 1'b1;
               hit_in   = ptr_ff[stsc_pkg::INDEX_W-1:0];
               count_in = stsc_pkg::COUNT_W'(1);
               ptr_in   = ptr_ff - stsc_pkg::PTR_W'(1);
               state_in = ST_L_ADDR;
            end else if (rd_data < key_ff) begin
               low_in   = ptr_ff + stsc_pkg::PTR_W'(1);
               state_in = ST_B_ADDR;
            end else begin
               high_in  = ptr_ff - stsc_pkg::PTR_W'(1);
               state_in = ST_B_ADDR;
            end
         end
         ST_L_ADDR: begin
            if (ptr_ff[stsc_pkg::PTR_W-1]) begin
               ptr_in   = hit_next_s;
               state_in = ST_R_ADDR;
            end else begin
               mem_req.rd_en = 1'b1;
               state_in      = ST_L_CMP;
            end
         end
         ST_L_CMP: begin
            if (rd_data == key_ff) begin
               count_in = count_ff + stsc_pkg::COUNT_W'(1);
               ptr_in   = ptr_ff - stsc_pkg::PTR_W'(1);
               state_in = ST_L_ADDR;
            end else begin
               ptr_in   = hit_next_s;
               state_in = ST_R_ADDR;
            end
         end
         ST_R_ADDR: begin
            if (ptr_ff >= len_s) begin
               state_in = ST_DONE;
            end else begin
               mem_req.rd_en = 1'b1;
               state_in      = ST_R_CMP;
            end
         end
         ST_R_CMP: begin
            if (rd_data == key_ff) begin
               count_in = count_ff + stsc_pkg::COUNT_W'(1);
               ptr_in   = ptr_ff + stsc_pkg::PTR_W'(1);
               state_in = ST_R_ADDR;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               result_valid = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign result.found       = found_ff;
   assign result.hit_index   = hit_ff;
   assign result.occurrences = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Writes only happen in idle, so a table write never overlaps a search read.
   always_ff @(posedge clock) begin
      low_ff   <= low_in;
      high_ff  <= high_in;
      ptr_ff   <= ptr_in;
      key_ff   <= key_in;
      found_ff <= found_in;
      hit_ff   <= hit_in;
      count_ff <= count_in;
   end

endmodule
`default_nettype wire

// ===== rtl/sorted_table_search_count_core.sv =====
// Top level of the sorted table search with occurrence count.
//
// The req channel carries write and query items; a transfer happens when
// req_valid is high and req_stall is low. A write stores one signed entry at
// the accept edge and returns nothing. A query searches entries 0 to
// table_length-1 (written on csr_wr_en/csr_wr_data, capped at the table depth)
// and returns one rsp item: found flag, hit index and occurrence count.
// A query runs binary search probes (one table read, one compare each),
// at most floor(log2(length))+1 of them, plus a failed range check when
// the target is absent. On a hit the left and right scans read and compare
// one entry at a time, plus a range check for each scan that stops at an
// end of the range without a read, and a done step hands the result to
// the rsp register. An empty table goes from the range check to done.
// The single table read port sets that pace; a write needs no read.
// One item is worked on at a time; req_stall is high while a query runs.
// The rsp output register lets a new item be taken while a result waits.
// If rsp_stall holds the register full when the next query finishes, the
// sequencer waits. Reset clears the length register, the sequencer and
// rsp_valid; table contents are undefined until written.
`default_nettype none
module sorted_table_search_count_core (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire stsc_pkg::req_type            req_data,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output stsc_pkg::rsp_type                 rsp_data,
   input  wire                               csr_wr_en,
   input  wire [stsc_pkg::LEN_W-1:0]         csr_wr_data
);

   logic [stsc_pkg::LEN_W-1:0]            table_length_ff;
   logic [stsc_pkg::LEN_W-1:0]            used_len;
   logic                                  rsp_valid_ff, rsp_valid_in;
   stsc_pkg::rsp_type                     rsp_data_ff;
   logic                                  rsp_free;
   logic                                  result_valid;
   stsc_pkg::rsp_type                     result;
   stsc_pkg::mem_req_type                 mem_req;
   logic signed [stsc_pkg::DATA_W-1:0]    rd_data;

   assign used_len = (32'(table_length_ff) > stsc_pkg::TABLE_DEPTH) ?
                     stsc_pkg::LEN_W'(stsc_pkg::TABLE_DEPTH) : table_length_ff;

   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = result_valid || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            table_length_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_valid) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   stsc_search_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .used_len     (used_len),
      .rsp_free     (rsp_free),
      .result_valid (result_valid),
      .result       (result),
      .mem_req      (mem_req),
      .rd_data      (rd_data)
   );

   stsc_table_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // A query transfer must close the input until its result is handed over.
   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.operation == stsc_pkg::OP_QUERY) |=> req_stall)
      else $error("query transfer did not block the input");

   // A miss reports zero index and zero count.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.hit_index == '0 &&
                                          rsp_data.occurrences == '0))
      else $error("miss result carries nonzero fields");

   // A hit counts at least itself and lies inside the searched range.
   a_hit_sane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |-> (rsp_data.occurrences != '0 &&
         {1'b0, rsp_data.hit_index} < used_len))
      else $error("hit result out of range");

   // A result is only produced while the output register can take it.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> rsp_free)
      else $error("result would overwrite a pending response");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the sorted table search with occurrence count.
`default_nettype none
module tb;
   import stsc_pkg::*;

   localparam int WATCHDOG_LIMIT = 50000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic signed [DATA_W-1:0] FILL_VALUE = 32'sh0000_1234;
   localparam rsp_type MISS = '0;

   typedef enum {ROW_ITEM, ROW_LEN, ROW_FILL} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type item;
      bit      typed;
      rsp_type want;
      int      len;
   } row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic [LEN_W-1:0] csr_wr_data;

   // Shadow copy of the table and the length register.
   logic signed [DATA_W-1:0] shadow_table [TABLE_DEPTH];
   logic [LEN_W-1:0]         shadow_len;
   rsp_type                  expected_rsp [$];
   rsp_type                  oldest_rsp;

   int send_idle_pct;
   int recv_idle_pct;
   int error_count;
   int quiet_cycles;

   row_type directed_rows [24] = '{
      '{ROW_ITEM, '{OP_QUERY, 10'd0, 32'sd5}, 1'b1, MISS, 0},
      '{ROW_FILL, '{OP_WRITE, 10'd0, FILL_VALUE}, 1'b0, MISS, 0},
      '{ROW_LEN, '{OP_WRITE, 10'd0, 32'sd0}, 1'b0, MISS, 1024},
      '{ROW_ITEM, '{OP_QUERY, 10'd0, FILL_VALUE}, 1'b1, '{1'b1, 10'd511, 11'd1024}, 0},
      '{ROW_ITEM, '{OP_QUERY, 10'h3ff, FILL_VALUE + 1}, 1'b1, MISS, 0},
      '{ROW_LEN, '{OP_WRITE, 10'd0, 32'sd0}, 1'b0, MISS, 2047},
      '{ROW_ITEM, '{OP_QUERY, 10'd0, FILL_VALUE}, 1'b1, '{1'b1, 10'd511, 11'd1024}, 0},
      '{ROW_LEN, '{OP_WRITE, 10'd0, 32'sd0}, 1'b0, MISS, 4},
      '{ROW_ITEM, '{OP_WRITE, 10'd0, 32'sh8000_0000}, 1'b0, MISS, 0},
      '{ROW_ITEM, '{OP_WRITE, 10'd1, -32'sd1}, 1'b0, MISS, 0},
      '{ROW_ITEM, '{OP_WRITE, 10'd2, -32'sd1}, 1'b0, MISS, 0},
      '{ROW_ITEM, '{OP_WRITE, 10'd3, 32'sh7fff_ffff}, 1'b0, MISS, 0},
      '{ROW_ITEM, '{OP_QUERY, 10'd0, -32'sd1}, 1'b1, '{1'b1, 10'd1, 11'd2}, 0},
      '{ROW_ITEM, '{OP_QUERY, 10'd0, 32'sh7fff_ffff}, 1'b1, '{1'b1, 10'd3, 11'd1}, 0},
      '{ROW_ITEM, '{OP_QUERY, 10'd0, 32'sh8000_0000}, 1'b1, '{1'b1, 10'd0, 11'd1}, 0},
      '{ROW_ITEM, '{OP_QUERY, 10'd0, 32'sd0}, 1'b1, MISS, 0},
      '{ROW_LEN, '{OP_WRITE, 10'd0, 32'sd0}, 1'b0, MISS, 1},
      '{ROW_ITEM, '{OP_QUERY, 10'd0, 32'sh8000_0000}, 1'b1, '{1'b1, 10'd0, 11'd1}, 0},
      '{ROW_LEN, '{OP_WRITE, 10'd0, 32'sd0}, 1'b0, MISS, 0},
      '{ROW_ITEM, '{OP_QUERY, 10'd0, 32'sh8000_0000}, 1'b1, MISS, 0},
      '{ROW_LEN, '{OP_WRITE, 10'd0, 32'sd0}, 1'b0, MISS, 2047},
      '{ROW_ITEM, '{OP_QUERY, 10'd0, FILL_VALUE}, 1'b0, MISS, 0},
      '{ROW_ITEM, '{OP_QUERY, 10'd0, -32'sd1}, 1'b0, MISS, 0},
      '{ROW_ITEM, '{OP_WRITE, 10'h3ff, 32'sh5a5a_a5a5}, 1'b0, MISS, 0}
   };

   sorted_table_search_count_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Binary search with the low+(high-low)/2 midpoint, then count equal neighbors.
   function automatic rsp_type search_count(input logic signed [DATA_W-1:0] target);
      int n;
      int lo;
      int hi;
      int mid;
      int hit;
      int l;
      int r;
      int cnt;
      rsp_type res;
      n = (shadow_len > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_len);
      lo = 0;
      hi = n - 1;
      hit = -1;
      res = '0;
      while (lo <= hi && hit < 0) begin
         mid = lo + (hi - lo) / 2;
         if (shadow_table[mid] == target) begin
            hit = mid;
         end else if (shadow_table[mid] < target) begin
            lo = mid + 1;
         end else begin
            hi = mid - 1;
         end
      end
      if (hit >= 0) begin
         cnt = 1;
         l = hit - 1;
         while (l >= 0 && shadow_table[l] == target) begin
            cnt++;
            l--;
         end
         r = hit + 1;
         while (r < n && shadow_table[r] == target) begin
            cnt++;
            r++;
         end
         res.found = 1'b1;
         res.hit_index = hit[INDEX_W-1:0];
         res.occurrences = cnt[COUNT_W-1:0];
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch in %s: got %0d, want %0d", what, got, want);
      error_count++;
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(input req_type it, input bit typed, input rsp_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (it.operation == OP_WRITE) begin
         shadow_table[it.entry_index] = it.value;
      end else begin
         expected_rsp.push_back(typed ? want : search_count(it.value));
      end
      @(negedge clock);
   endtask

   task automatic send_write(input int idx, input logic signed [DATA_W-1:0] v);
      req_type it;
      it.operation = OP_WRITE;
      it.entry_index = idx[INDEX_W-1:0];
      it.value = v;
      send_item(it, 1'b0, MISS);
   endtask

   task automatic send_query(input logic signed [DATA_W-1:0] v);
      req_type it;
      it.operation = OP_QUERY;
      it.entry_index = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
      it.value = v;
      send_item(it, 1'b0, MISS);
   endtask

   // The length register is only written once every query has been answered.
   task automatic set_length(input int len);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= len[LEN_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      shadow_len = len[LEN_W-1:0];
   endtask

   // One phase: pick a length, write a sorted run with duplicates, then query it.
   task automatic run_phase();
      int len;
      int start;
      int span;
      int step_max;
      int nq;
      int k;
      int pick;
      longint run_val;
      logic signed [DATA_W-1:0] v;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         len = 0;
      end else if (pick == 1) begin
         len = TABLE_DEPTH;
      end else if (pick == 2) begin
         len = ($urandom_range(0, 1) == 0) ? 2047 : $urandom_range(TABLE_DEPTH + 1, 2046);
      end else begin
         len = $urandom_range(1, 40);
      end
      set_length(len);
      if (len == 0) begin
         start = 0;
         span = $urandom_range(1, 8);
      end else if (len <= 40) begin
         start = 0;
         span = len;
      end else begin
         span = $urandom_range(16, 48);
         start = $urandom_range(0, TABLE_DEPTH - span);
      end
      case ($urandom_range(0, 3))
         0: run_val = -64'sd2147483648;
         1: run_val = 64'sd2147483647 - span * $urandom_range(0, 3);
         2: run_val = $signed($urandom);
         default: run_val = $signed($urandom_range(0, 200)) - 100;
      endcase
      case ($urandom_range(0, 2))
         0: step_max = 1;
         1: step_max = 4;
         default: step_max = 1 << 20;
      endcase
      for (k = 0; k < span; k++) begin
         if ($urandom_range(0, 99) < 5) begin
            send_query($signed($urandom));
         end
         send_write(start + k, run_val[DATA_W-1:0]);
         if ($urandom_range(0, 2) != 0) begin
            run_val += $urandom_range(1, step_max);
         end
         if (run_val > 64'sd2147483647) begin
            run_val = 64'sd2147483647;
         end
      end
      nq = $urandom_range(12, 28);
      for (k = 0; k < nq; k++) begin
         pick = $urandom_range(0, 99);
         v = shadow_table[start + $urandom_range(0, span - 1)];
         if (pick < 65) begin
            send_query(v);
         end else if (pick < 80) begin
            send_query(($urandom_range(0, 1) == 0) ? v + 1 : v - 1);
         end else if (pick < 92) begin
            send_query($signed($urandom));
         end else begin
            // A stray write that may leave the table out of order.
            send_write($urandom_range(0, TABLE_DEPTH - 1), $signed($urandom));
         end
      end
   endtask

   // Receiver stall pattern.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected result, found", rsp_data.found, 0);
         end else begin
            oldest_rsp = expected_rsp.pop_front();
            if (rsp_data.found !== oldest_rsp.found) begin
               report_mismatch("found", rsp_data.found, oldest_rsp.found);
            end
            if (rsp_data.hit_index !== oldest_rsp.hit_index) begin
               report_mismatch("hit_index", rsp_data.hit_index, oldest_rsp.hit_index);
            end
            if (rsp_data.occurrences !== oldest_rsp.occurrences) begin
               report_mismatch("occurrences", rsp_data.occurrences,
                               oldest_rsp.occurrences);
            end
         end
      end
   end

   // Ends the run if no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   initial begin
      int j;
      int mode;
      int ph;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      shadow_len = '0;
      error_count = 0;
      quiet_cycles = 0;
      send_idle_pct = 32;
      recv_idle_pct = 70;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_LEN: begin
               set_length(directed_rows[i].len);
            end
            ROW_FILL: begin
               for (j = 0; j < TABLE_DEPTH; j++) begin
                  send_write(j, directed_rows[i].item.value);
               end
            end
            default: begin
               send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
            end
         endcase
      end

      for (mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 70 : 0;
         recv_idle_pct = (mode == 0) ? 70 : (mode == 1) ? 32 : 0;
         for (ph = 0; ph < 2; ph++) begin
            run_phase();
         end
      end

      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
